@@ rtl/core/b64_pkg.sv @@
// shared types, constants and character mapping for the base64 stream codec
package b64_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   localparam logic [7:0] PAD_CHAR = 8'h3d;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // one queued group: up to four words, last_idx is the count minus one
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
      logic            valid;
      logic            last;
   } cmd_type;

   typedef struct packed {
      logic direction;
      logic clear;
   } cfg_type;

   function automatic logic [7:0] enc_char(input logic [5:0] idx);
      logic [7:0] x;
      x = {2'b00, idx};
      if (idx < 6'd26) return x + 8'd65;
      else if (idx < 6'd52) return x + 8'd71;
      else if (idx < 6'd62) return x - 8'd4;
      else if (idx == 6'd62) return 8'h2b;
      else return 8'h2f;
   endfunction

   // bit 6 set when the character is in the alphabet
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h41 && c <= 8'h5a) begin
         v = c - 8'd65;
         return {1'b1, v[5:0]};
      end
      if (c >= 8'h61 && c <= 8'h7a) begin
         v = c - 8'd71;
         return {1'b1, v[5:0]};
      end
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c + 8'd4;
         return {1'b1, v[5:0]};
      end
      if (c == 8'h2b) return {1'b1, 6'd62};
      if (c == 8'h2f) return {1'b1, 6'd63};
      return 7'd0;
   endfunction

endpackage

@@ rtl/core/b64_front.sv @@
// front end: accepts words, tracks group state and builds group commands
module b64_front (
   input  logic            clock,
   input  logic            reset,
   input  b64_pkg::cfg_type cfg,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      req_tdata,
   input  logic            req_tlast,
   input  logic            q_full,
   output logic            push,
   output b64_pkg::cmd_type cmd
);
   import b64_pkg::*;

   logic [17:0] bits_ff, bits_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        stop_ff, stop_in;

   logic        accept;
   logic [6:0]  sx;
   logic [17:0] nb8;
   logic [23:0] v;
   logic [17:0] dbits;
   logic [1:0]  dcnt;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   always_comb begin
      bits_in = bits_ff;
      cnt_in  = cnt_ff;
      stop_in = stop_ff;
      push    = 1'b0;
      cmd     = '0;
      sx      = sextet_of(req_tdata);
      nb8     = {bits_ff[9:0], req_tdata};
      v       = '0;
      dbits   = bits_ff;
      dcnt    = cnt_ff;
      if (cfg.clear) begin
         bits_in = '0;
         cnt_in  = '0;
         stop_in = 1'b0;
      end else if (accept) begin
         if (cfg.direction == DIR_ENCODE) begin
            if (cnt_ff == 2'd2) begin
               v = {bits_ff[15:0], req_tdata};
               cmd.data[0]  = enc_char(v[23:18]);
               cmd.data[1]  = enc_char(v[17:12]);
               cmd.data[2]  = enc_char(v[11:6]);
               cmd.data[3]  = enc_char(v[5:0]);
               cmd.last_idx = 2'd3;
               cmd.valid    = 1'b1;
               cmd.last     = req_tlast;
               push         = 1'b1;
               bits_in      = '0;
               cnt_in       = '0;
            end else begin
               bits_in = nb8;
               cnt_in  = cnt_ff + 2'd1;
               if (req_tlast) begin
                  if (cnt_ff == 2'd0) v = {req_tdata, 16'h0000};
                  else v = {nb8[15:0], 8'h00};
                  cmd.data[0]  = enc_char(v[23:18]);
                  cmd.data[1]  = enc_char(v[17:12]);
                  cmd.data[2]  = (cnt_ff == 2'd1) ? enc_char(v[11:6]) : PAD_CHAR;
                  cmd.data[3]  = PAD_CHAR;
                  cmd.last_idx = 2'd3;
                  cmd.valid    = 1'b1;
                  cmd.last     = 1'b1;
                  push         = 1'b1;
               end
            end
            if (req_tlast) begin
               bits_in = '0;
               cnt_in  = '0;
               stop_in = 1'b0;
            end
         end else begin
            if (!stop_ff) begin
               if (!sx[6]) begin
                  stop_in = 1'b1;
               end else if (cnt_ff == 2'd3) begin
                  v = {bits_ff, sx[5:0]};
                  cmd.data[0]  = v[23:16];
                  cmd.data[1]  = v[15:8];
                  cmd.data[2]  = v[7:0];
                  cmd.last_idx = 2'd2;
                  cmd.valid    = 1'b1;
                  cmd.last     = req_tlast;
                  push         = 1'b1;
                  dbits        = '0;
                  dcnt         = '0;
               end else begin
                  dbits = {bits_ff[11:0], sx[5:0]};
                  dcnt  = cnt_ff + 2'd1;
               end
            end
            bits_in = dbits;
            cnt_in  = dcnt;
            if (req_tlast) begin
               if (!push) begin
                  push     = 1'b1;
                  cmd.last = 1'b1;
                  case (dcnt)
                     2'd2: begin
                        cmd.data[0]  = dbits[11:4];
                        cmd.last_idx = 2'd0;
                        cmd.valid    = 1'b1;
                     end
                     2'd3: begin
                        cmd.data[0]  = dbits[17:10];
                        cmd.data[1]  = dbits[9:2];
                        cmd.last_idx = 2'd1;
                        cmd.valid    = 1'b1;
                     end
                     default: begin
                        cmd.last_idx = 2'd0;
                        cmd.valid    = 1'b0;
                     end
                  endcase
               end
               bits_in = '0;
               cnt_in  = '0;
               stop_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
         cnt_ff  <= '0;
         stop_ff <= 1'b0;
      end else begin
         bits_ff <= bits_in;
         cnt_ff  <= cnt_in;
         stop_ff <= stop_in;
      end
   end

endmodule

@@ rtl/core/b64_queue.sv @@
// short command queue between front end and back end
module b64_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  b64_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output b64_pkg::cmd_type head,
   output logic             empty
);
   import b64_pkg::*;

   cmd_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QDEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/b64_back.sv @@
// back end: serializes group commands into the output register
module b64_back (
   input  logic             clock,
   input  logic             reset,
   input  b64_pkg::cmd_type head,
   input  logic             empty,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tuser,
   output logic             rsp_tlast
);
   import b64_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       user_ff, user_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       at_end;

   assign load   = (!valid_ff || rsp_tready) && !empty;
   assign at_end = (idx_ff == head.last_idx);
   assign pop    = load && at_end;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = head.data[idx_ff];
         user_in  = head.valid;
         last_in  = head.last && at_end;
         idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

@@ rtl/core/base64_stream_codec_core.sv @@
// top level of the base64 stream codec: register port, front end, queue, back end
//
//   channel  dir  data                         side bits
//   req      in   tdata: byte or character     tlast: end of message
//   rsp      out  tdata: character or byte     tuser: data valid, tlast: last
//   csr      in   direction at offset 0        pready always high
//
// one input word is taken per cycle while the four-entry command queue has room
// the back end sends one output word per cycle while the receiver is ready, so encoding is held
// back by the single output register; decoding takes one per cycle
// reset is synchronous; a direction write clears the group state
// either side may stall; the queue lets the front keep taking words meanwhile
module base64_stream_codec_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_in
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] data_out
   output logic        rsp_tuser,   // [0] data_valid
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import b64_pkg::*;

   logic    direction_ff, direction_in;
   logic    dir_write;
   cfg_type cfg;
   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   cmd_type q_head;

   assign csr_pready   = 1'b1;
   assign dir_write    = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0);
   assign direction_in = dir_write ? csr_pwdata[0] : direction_ff;
   assign csr_prdata   = {31'd0, direction_ff};

   always_ff @(posedge clock) begin
      if (reset) direction_ff <= DIR_ENCODE;
      else direction_ff <= direction_in;
   end

   assign cfg = {direction_ff, dir_write};

   b64_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   b64_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   b64_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .empty      (q_empty),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_bare_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("bare end marker without last");

   a_encode_always_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (direction_ff == DIR_ENCODE) |-> rsp_tuser)
      else $error("bare marker while encoding");

   a_bare_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'h00)
      else $error("bare end marker carries data");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid right after reset");
`endif

endmodule

@@ sim/tb_base64_stream_codec_core.sv @@
// self-checking testbench for the base64 stream codec core, both directions, random stalls
`timescale 1ns / 100ps

typedef struct packed {
   logic [7:0] data;
   logic       valid;
   logic       last;
} b64_word_type;

class b64_scoreboard;
   logic         dir_sel;
   logic [17:0]  grp_bits;
   logic [1:0]   grp_cnt;
   logic         stopped;
   b64_word_type expected_words[$];
   int           mismatches;
   int           words_in;
   int           words_out;

   function new();
      dir_sel = b64_pkg::DIR_ENCODE;
      clear_group();
      mismatches = 0;
      words_in = 0;
      words_out = 0;
   endfunction

   static function logic [7:0] alphabet_char(input int idx);
      logic [8*64-1:0] chars;
      chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      return chars[8*(63-idx) +: 8];
   endfunction

   function void clear_group();
      grp_bits = '0;
      grp_cnt = '0;
      stopped = 1'b0;
   endfunction

   function void set_direction(input logic d);
      dir_sel = d;
      clear_group();
   endfunction

   function void push(input logic [7:0] d, input logic v, input logic l);
      b64_word_type w;
      w.data = d;
      w.valid = v;
      w.last = l;
      expected_words.insert(expected_words.size(), w);
   endfunction

   function void note_input(input logic [7:0] d, input logic eom);
      logic [23:0] v;
      int          n;
      int          cnt;
      int          s;
      int          k;
      int          sx;
      words_in++;
      n = 0;
      if (dir_sel == b64_pkg::DIR_ENCODE) begin
         if (grp_cnt == 2'd2) begin
            v = {grp_bits[15:0], d};
            for (s = 0; s < 4; s++) begin
               push(alphabet_char(int'(v[23-6*s -: 6])), 1'b1, eom && s == 3);
            end
            grp_bits = '0;
            grp_cnt = '0;
         end else begin
            grp_bits = {grp_bits[9:0], d};
            grp_cnt++;
            if (eom) begin
               cnt = grp_cnt;
               v = {8'h00, grp_bits[15:0]} << (8*(3-cnt));
               for (s = 0; s < 4; s++) begin
                  push((s <= cnt) ? alphabet_char(int'(v[23-6*s -: 6])) : b64_pkg::PAD_CHAR,
                       1'b1, s == 3);
               end
            end
         end
         if (eom) clear_group();
      end else begin
         if (!stopped) begin
            sx = -1;
            for (k = 0; k < 64; k++) begin
               if (alphabet_char(k) == d) sx = k;
            end
            if (sx < 0) begin
               stopped = 1'b1;
            end else if (grp_cnt == 2'd3) begin
               v = {grp_bits, sx[5:0]};
               push(v[23:16], 1'b1, 1'b0);
               push(v[15:8], 1'b1, 1'b0);
               push(v[7:0], 1'b1, eom);
               n = 3;
               grp_bits = '0;
               grp_cnt = '0;
            end else begin
               grp_bits = {grp_bits[11:0], sx[5:0]};
               grp_cnt++;
            end
         end
         if (eom) begin
            cnt = grp_cnt;
            v = {6'b0, grp_bits} << (6*(4-cnt));
            for (k = 0; k + 1 < cnt; k++) begin
               push(v[23-8*k -: 8], 1'b1, k + 2 == cnt);
               n++;
            end
            // message ended with nothing to send
            if (n == 0) push(8'h00, 1'b0, 1'b1);
            clear_group();
         end
      end
   endfunction

   function void check_output(input logic [7:0] d, input logic v, input logic l);
      b64_word_type w;
      words_out++;
      if (expected_words.size() == 0) begin
         $error("unexpected output word: data_out %h data_valid %b last_out %b", d, v, l);
         mismatches++;
         return;
      end
      w = expected_words.pop_front();
      if (w.data !== d) begin
         $error("data_out mismatch: expected %h, actual %h", w.data, d);
         mismatches++;
      end
      if (w.valid !== v) begin
         $error("data_valid mismatch: expected %b, actual %b", w.valid, v);
         mismatches++;
      end
      if (w.last !== l) begin
         $error("last_out mismatch: expected %b, actual %b", w.last, l);
         mismatches++;
      end
   endfunction

   function void report_leftover();
      if (expected_words.size() != 0) begin
         $error("%0d expected output words never arrived", expected_words.size());
         mismatches++;
      end
   endfunction
endclass

module tb_base64_stream_codec_core;
   import b64_pkg::*;

   localparam logic [2:0] DIRECTION_ADDR = 3'd0;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_in
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // [7:0] data_out
   logic        rsp_tuser;           // [0] data_valid
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   b64_scoreboard sb;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int stall_cycles = 0;
   int n_writes = 0;
   int sender_pct_tab[4] = '{0, 74, 0, 24};
   int stall_pct_tab[4] = '{0, 0, 74, 24};

   base64_stream_codec_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_output(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   task send_word(input logic [7:0] d, input logic eom);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= eom;
      do @(posedge clock); while (!req_tready);
      sb.note_input(d, eom);
   endtask

   task send_chars(input logic [63:0] text, input int len, input logic eom);
      int k;
      for (k = 0; k < len; k++) begin
         send_word(text[8*(len-1-k) +: 8], eom && k == len - 1);
      end
   endtask

   task wait_drained(input int extra);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.expected_words.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task write_direction(input logic d);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= DIRECTION_ADDR;
      csr_pwdata <= {31'd0, d};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_direction(d);
      n_writes++;
   endtask

   task run_messages(input logic dir, input int n_items);
      int         sent;
      int         msg;
      int         len;
      int         total;
      int         kind;
      int         k;
      logic [7:0] c;
      sent = 0;
      msg = 0;
      while (sent < n_items) begin
         len = ($urandom_range(3) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
         kind = $urandom_range(9);
         total = len;
         // well-formed decode text, sometimes padded out to a full group
         if (dir == DIR_DECODE && kind >= 2 && len % 4 >= 2 && $urandom_range(1) == 1)
            total = len + 4 - len % 4;
         for (k = 0; k < total; k++) begin
            if (dir == DIR_ENCODE) c = 8'($urandom_range(255));
            else if (k >= len) c = PAD_CHAR;
            else if (kind < 2 && $urandom_range(3) == 0)
               c = $urandom_range(1) ? PAD_CHAR : 8'($urandom_range(255));
            else c = sb.alphabet_char($urandom_range(63));
            send_word(c, k == total - 1);
         end
         sent += total;
         msg++;
         if (msg == 2) wait_drained(0);
      end
   endtask

   initial begin
      int p;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_direction(DIR_ENCODE);
      send_chars(64'hFF, 1, 1'b1);
      send_chars(64'h00FF, 2, 1'b1);
      send_chars(64'hFF007F, 3, 1'b1);
      // open group dropped by the direction change
      send_chars(64'hAA55, 2, 1'b0);
      wait_drained(SETTLE_CYCLES);

      write_direction(DIR_DECODE);
      send_chars("TWFu", 4, 1'b1);
      send_chars("/+9A=", 5, 1'b1);
      send_chars("Zz", 2, 1'b1);
      send_chars("a", 1, 1'b1);
      send_chars("QU*x", 4, 1'b1);
      send_chars(64'hFF, 1, 1'b1);
      send_chars("Ab", 2, 1'b0);
      wait_drained(SETTLE_CYCLES);

      for (p = 0; p < 4; p++) begin
         send_idle_pct = sender_pct_tab[p];
         recv_stall_pct = stall_pct_tab[p];
         write_direction(DIR_ENCODE);
         run_messages(DIR_ENCODE, 10);
         wait_drained(SETTLE_CYCLES);
         write_direction(DIR_DECODE);
         run_messages(DIR_DECODE, 10);
         wait_drained(SETTLE_CYCLES);
      end

      sb.report_leftover();
      $display("covered %0d input words and %0d output words in both directions, %0d mode writes",
               sb.words_in, sb.words_out, n_writes);
      $display("idle mixes: none, sender gaps, receiver stalls, both together");
      if (sb.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
